/* rtl/mmf_pkg.sv */
package mmf_pkg;

  // Default table depth.
  localparam int MAX_ENTRIES_DEF = 16;

  // Field widths of the command and result words.
  localparam int CMD_W      = 2;
  localparam int GROUP_W    = 32;
  localparam int MAC_W      = 48;
  localparam int LOW_W      = 23;
  localparam int COUNT_W    = 5;
  localparam int REF_W      = 16;
  localparam int OVF_W      = 16;

  // IPv4 multicast MAC prefix 01:00:5e; the bit below it is always zero.
  localparam logic [23:0]      MAC_PREFIX = 24'h01005E;
  localparam logic [REF_W-1:0] REF_MAX    = 16'hFFFF;
  localparam logic [OVF_W-1:0] OVF_MAX    = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_JOIN  = 2'd0,
    CMD_LEAVE = 2'd1,
    CMD_SNAP  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  // One table entry as stored in the entry RAM.
  typedef struct packed {
    logic [LOW_W-1:0] mac_low;
    logic [REF_W-1:0] ref_cnt;
  } entry_t;

  // Status from the compare unit to the sequencer.
  typedef struct packed {
    logic             hit;
    logic             done;
    logic [REF_W-1:0] cnt;
  } match_t;

  // One result word.
  typedef struct packed {
    logic [MAC_W-1:0]   mac_address;
    logic               entry_valid;
    logic               last_of_run;
    logic [COUNT_W-1:0] entry_count;
    logic [OVF_W-1:0]   overflow_count;
    logic               filter_dirty;
    logic               list_changed;
  } result_t;

endpackage

/* rtl/mmf_req_if.sv */
interface mmf_req_if;
  logic                         valid;
  logic                         ready;
  logic [mmf_pkg::CMD_W-1:0]    command;
  logic [mmf_pkg::GROUP_W-1:0]  group_address;

  modport source (output valid, command, group_address, input ready);
  modport sink   (input valid, command, group_address, output ready);
endinterface

/* rtl/mmf_res_if.sv */
interface mmf_res_if;
  logic                         valid;
  logic                         ready;
  logic [mmf_pkg::MAC_W-1:0]    mac_address;
  logic                         entry_valid;
  logic                         last_of_run;
  logic [mmf_pkg::COUNT_W-1:0]  entry_count;
  logic [mmf_pkg::OVF_W-1:0]    overflow_count;
  logic                         filter_dirty;
  logic                         list_changed;

  modport source (output valid, mac_address, entry_valid, last_of_run, entry_count,
                  overflow_count, filter_dirty, list_changed, input ready);
  modport sink   (input valid, mac_address, entry_valid, last_of_run, entry_count,
                  overflow_count, filter_dirty, list_changed, output ready);
endinterface

/* rtl/multicast_mac_filter_table_core.sv */
// Multicast MAC filter table with reference counts. Each word on the request
// channel is a join, leave or snapshot; join and leave return one result word
// carrying the mapped MAC 01:00:5e plus the group's low 23 bits, snapshot
// returns one word per table entry (or one empty word) and clears the dirty
// flag. Entries live in a single RAM with one read port, and a join or leave
// walks the used entries one per cycle through a shared compare unit; when a
// leave removes an entry, the last entry is moved into its slot. A snapshot
// reads each entry and then emits its word, one entry after the other. The
// request side is ready only between items; a finished result waits in the
// output register without holding up the next request. A reserved command
// is dropped without a result. The table starts empty after reset and needs
// no clearing pass.
module multicast_mac_filter_table_core #(
  parameter int MAX_ENTRIES = mmf_pkg::MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mmf_req_if.sink   request,
  mmf_res_if.source result
);
  import mmf_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_DECIDE,
    S_MOVE,
    S_EMIT,
    S_SNAP_RD,
    S_SNAP_OUT
  } state_t;

  state_t           state;
  cmd_t             cmd_r;
  logic [LOW_W-1:0] key;
  logic [CW-1:0]    scan;
  logic [CW-1:0]    used;
  logic [OVF_W-1:0] ovf;
  logic             dirty;
  logic             found;
  logic [IW-1:0]    found_idx;
  logic [REF_W-1:0] found_cnt;
  logic             changed;
  result_t          res;
  logic             res_valid;

  logic             slot_free;
  logic             search_issue;
  logic             has_room;
  logic             remove;
  logic [CW-1:0]    used_m1;
  match_t           mstat;
  logic [IW-1:0]    midx;

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;

  assign request.ready = (state == S_IDLE);
  assign slot_free     = !res_valid || result.ready;
  assign has_room      = used < CW'(MAX_ENTRIES);
  assign used_m1       = used - CW'(1);
  assign remove        = (cmd_r == CMD_LEAVE) && found && (found_cnt == REF_W'(1));
  assign search_issue  = (state == S_SRCH) && (scan < used) && !mstat.hit && !mstat.done;

  // Entry storage.
  mmf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared compare unit for the table walk.
  mmf_match #(
    .IW (IW),
    .CW (CW)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .issue     (search_issue),
    .issue_idx (scan),
    .used      (used),
    .key       (key),
    .rd_data   (rd_data),
    .status    (mstat),
    .idx       (midx)
  );

  // RAM port steering per sequencer state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = found_idx;
    wr_data = '{mac_low: key, ref_cnt: found_cnt};
    case (state)
      S_SRCH: begin
        rd_en = search_issue;
      end
      S_DECIDE: begin
        if (cmd_r == CMD_JOIN) begin
          if (found) begin
            wr_en   = 1'b1;
            wr_data = '{mac_low: key,
                        ref_cnt: (found_cnt == REF_MAX) ? REF_MAX : found_cnt + REF_W'(1)};
          end else if (has_room) begin
            wr_en   = 1'b1;
            wr_addr = used[IW-1:0];
            wr_data = '{mac_low: key, ref_cnt: REF_W'(1)};
          end
        end else if (found) begin
          if (remove) begin
            rd_en   = 1'b1;
            rd_addr = used_m1[IW-1:0];
          end else begin
            wr_en   = 1'b1;
            wr_data = '{mac_low: key, ref_cnt: found_cnt - REF_W'(1)};
          end
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      S_SNAP_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, table bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      ovf       <= '0;
      dirty     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            cmd_r   <= cmd_t'(request.command);
            key     <= request.group_address[LOW_W-1:0];
            scan    <= '0;
            changed <= 1'b0;
            found   <= 1'b0;
            case (cmd_t'(request.command))
              CMD_JOIN, CMD_LEAVE: begin
                state <= (used == '0) ? S_DECIDE : S_SRCH;
              end
              CMD_SNAP: begin
                dirty <= 1'b0;
                state <= (used == '0) ? S_EMIT : S_SNAP_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (search_issue) begin
            scan <= scan + CW'(1);
          end
          if (mstat.hit) begin
            found     <= 1'b1;
            found_idx <= midx;
            found_cnt <= mstat.cnt;
            state     <= S_DECIDE;
          end else if (mstat.done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_EMIT;
          if (cmd_r == CMD_JOIN) begin
            if (!found) begin
              if (has_room) begin
                used    <= used + CW'(1);
                changed <= 1'b1;
                dirty   <= 1'b1;
              end else if (ovf != OVF_MAX) begin
                ovf <= ovf + OVF_W'(1);
                if (ovf == '0) begin
                  dirty <= 1'b1;
                end
              end
            end
          end else if (found) begin
            if (remove) begin
              used    <= used_m1;
              changed <= 1'b1;
              dirty   <= 1'b1;
              state   <= S_MOVE;
            end
          end else if (ovf != '0) begin
            ovf <= ovf - OVF_W'(1);
            if (ovf == OVF_W'(1)) begin
              dirty <= 1'b1;
            end
          end
        end
        S_MOVE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            res.mac_address    <= (cmd_r == CMD_SNAP) ? '0 : {MAC_PREFIX, 1'b0, key};
            res.entry_valid    <= 1'b0;
            res.last_of_run    <= 1'b1;
            res.entry_count    <= COUNT_W'(used);
            res.overflow_count <= ovf;
            res.filter_dirty   <= dirty;
            res.list_changed   <= changed;
            res_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        S_SNAP_RD: begin
          state <= S_SNAP_OUT;
        end
        S_SNAP_OUT: begin
          if (slot_free) begin
            res.mac_address    <= {MAC_PREFIX, 1'b0, rd_data.mac_low};
            res.entry_valid    <= 1'b1;
            res.last_of_run    <= (scan + CW'(1)) == used;
            res.entry_count    <= COUNT_W'(used);
            res.overflow_count <= ovf;
            res.filter_dirty   <= dirty;
            res.list_changed   <= 1'b0;
            res_valid          <= 1'b1;
            if ((scan + CW'(1)) == used) begin
              state <= S_IDLE;
            end else begin
              scan  <= scan + CW'(1);
              state <= S_SNAP_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drive the result channel from the output register.
  assign result.valid          = res_valid;
  assign result.mac_address    = res.mac_address;
  assign result.entry_valid    = res.entry_valid;
  assign result.last_of_run    = res.last_of_run;
  assign result.entry_count    = res.entry_count;
  assign result.overflow_count = res.overflow_count;
  assign result.filter_dirty   = res.filter_dirty;
  assign result.list_changed   = res.list_changed;

endmodule

/* rtl/mmf_ram.sv */
module mmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/mmf_match.sv */
module mmf_match #(
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         issue,
  input  logic [CW-1:0]                issue_idx,
  input  logic [CW-1:0]                used,
  input  logic [mmf_pkg::LOW_W-1:0]    key,
  input  mmf_pkg::entry_t              rd_data,
  output mmf_pkg::match_t              status,
  output logic [IW-1:0]                idx
);
  import mmf_pkg::*;

  logic          valid;
  logic [CW-1:0] idx_r;
  logic          equal;
  logic          at_last;

  // Track which entry the RAM read data belongs to.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= issue;
    end
    idx_r <= issue_idx;
  end

  // Compare the fetched entry against the search key.
  always_comb begin
    equal          = valid && (rd_data.mac_low == key);
    at_last        = (idx_r + CW'(1)) == used;
    status.hit     = equal;
    status.done    = valid && !equal && at_last;
    status.cnt     = rd_data.ref_cnt;
    idx            = idx_r[IW-1:0];
  end

endmodule

/* rtl/mmf_checker.sv */
module mmf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [mmf_pkg::CMD_W-1:0]   req_command,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [mmf_pkg::MAC_W-1:0]   res_mac_address,
  input logic                        res_entry_valid,
  input logic [mmf_pkg::COUNT_W-1:0] res_entry_count,
  input logic                        res_filter_dirty,
  input logic                        res_list_changed
);
  import mmf_pkg::*;

  // A stalled result word stays valid and keeps its MAC address.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_mac_address))
    else $error("result word changed while stalled");

  // Any real command keeps the request side busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_command != CMD_RSVD) |=> !req_ready)
    else $error("request accepted again right after a command");

  // Inserting or removing an entry always marks the filter dirty.
  a_dirty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_list_changed |-> res_filter_dirty)
    else $error("list changed without dirty flag");

  // Snapshot entries never report a change and always show a clean filter.
  a_snap_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_entry_valid |-> !res_list_changed && !res_filter_dirty)
    else $error("snapshot entry carries change or dirty flag");

  // A snapshot entry comes only from a nonempty table.
  a_snap_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_entry_valid |-> res_entry_count != '0)
    else $error("snapshot entry from an empty table");

endmodule

bind multicast_mac_filter_table_core mmf_checker u_mmf_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (request.valid),
  .req_ready        (request.ready),
  .req_command      (request.command),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .res_mac_address  (result.mac_address),
  .res_entry_valid  (result.entry_valid),
  .res_entry_count  (result.entry_count),
  .res_filter_dirty (result.filter_dirty),
  .res_list_changed (result.list_changed)
);

/* tb/mmf_filter_checker.sv */
// Watches the request and result channels of the multicast filter table,
// keeps its own copy of the table, and compares every result word with the
// oldest word still expected.
module mmf_filter_checker (
  input  logic clk,
  input  logic rst,
  mmf_req_if   request,
  mmf_res_if   result,
  output int   mismatches,
  output int   expected_left
);
  import mmf_pkg::*;

  localparam int SLOTS = MAX_ENTRIES_DEF;

  // Predicted table contents and flags.
  logic [LOW_W-1:0] slot_low  [SLOTS];
  logic [REF_W-1:0] slot_refs [SLOTS];
  int               slot_used;
  logic [OVF_W-1:0] groups_dropped;
  logic             push_pending;
  result_t          expected_words [$];

  // Apply one accepted request word to the table copy and queue its results.
  task automatic predict_word(input cmd_t op, input logic [GROUP_W-1:0] group);
    logic [LOW_W-1:0] low;
    int               hit;
    logic             had_drops;
    logic             resized;
    result_t          w;
    begin
      low = group[LOW_W-1:0];
      hit = -1;
      resized = 1'b0;
      w = '0;
      case (op)
        CMD_SNAP: begin
          push_pending = 1'b0;
          w.entry_count = COUNT_W'(slot_used);
          w.overflow_count = groups_dropped;
          if (slot_used == 0) begin
            w.last_of_run = 1'b1;
            expected_words.push_back(w);
          end else begin
            for (int i = 0; i < slot_used; i++) begin
              w.mac_address = {MAC_PREFIX, 1'b0, slot_low[i]};
              w.entry_valid = 1'b1;
              w.last_of_run = (i == slot_used - 1);
              expected_words.push_back(w);
            end
          end
        end
        CMD_JOIN, CMD_LEAVE: begin
          for (int i = 0; i < slot_used; i++) begin
            if (hit < 0 && slot_low[i] == low) hit = i;
          end
          had_drops = (groups_dropped != '0);
          if (op == CMD_JOIN) begin
            if (hit >= 0) begin
              if (slot_refs[hit] != REF_MAX) slot_refs[hit] = slot_refs[hit] + 1'b1;
            end else if (slot_used < SLOTS) begin
              slot_low[slot_used] = low;
              slot_refs[slot_used] = REF_W'(1);
              slot_used++;
              resized = 1'b1;
            end else if (groups_dropped != OVF_MAX) begin
              groups_dropped = groups_dropped + 1'b1;
            end
          end else begin
            if (hit >= 0) begin
              slot_refs[hit] = slot_refs[hit] - 1'b1;
              // The last entry moves into the freed slot.
              if (slot_refs[hit] == '0) begin
                slot_used--;
                slot_low[hit] = slot_low[slot_used];
                slot_refs[hit] = slot_refs[slot_used];
                resized = 1'b1;
              end
            end else if (groups_dropped != '0) begin
              groups_dropped = groups_dropped - 1'b1;
            end
          end
          if (resized || ((groups_dropped != '0) != had_drops)) push_pending = 1'b1;
          w.mac_address = {MAC_PREFIX, 1'b0, low};
          w.last_of_run = 1'b1;
          w.entry_count = COUNT_W'(slot_used);
          w.overflow_count = groups_dropped;
          w.filter_dirty = push_pending;
          w.list_changed = resized;
          expected_words.push_back(w);
        end
        default: begin
          // The reserved command is dropped without a result.
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
    begin
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    end
  endtask

  // Compare each accepted result word with the oldest expected word, then
  // predict from the request word accepted at the same edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      slot_used = 0;
      groups_dropped = '0;
      push_pending = 1'b0;
      mismatches = 0;
      expected_words.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word with mac %0h expected none", $time,
                   result.mac_address);
        end else begin
          want = expected_words.pop_front();
          check_field("mac_address", want.mac_address, result.mac_address);
          check_field("entry_valid", want.entry_valid, result.entry_valid);
          check_field("last_of_run", want.last_of_run, result.last_of_run);
          check_field("entry_count", want.entry_count, result.entry_count);
          check_field("overflow_count", want.overflow_count, result.overflow_count);
          check_field("filter_dirty", want.filter_dirty, result.filter_dirty);
          check_field("list_changed", want.list_changed, result.list_changed);
        end
      end
      if (request.valid && request.ready) begin
        predict_word(cmd_t'(request.command), request.group_address);
      end
    end
    expected_left = expected_words.size();
  end

endmodule

/* tb/tb.sv */
module tb;
  import mmf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_WORDS = 14;
  localparam int POOL_SIZE     = 24;
  localparam int HOLD_CYCLES   = 400;

  // Low MAC bits kept clear of the pool, for the directed sweeps.
  localparam logic [LOW_W-1:0] SAT_REF_LOW  = 23'h5A00FF;
  localparam logic [LOW_W-1:0] FILL_BASE    = 23'h5A0000;
  localparam logic [LOW_W-1:0] SPILL_LOW    = 23'h5A0080;
  localparam logic [LOW_W-1:0] ABSENT_LOW   = 23'h5A0081;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   expected_left;
  int   cycles;
  bit   idle_on;
  bit   hold_results;
  logic [LOW_W-1:0] group_pool [POOL_SIZE];

  mmf_req_if request_ch ();
  mmf_res_if result_ch ();

  multicast_mac_filter_table_core dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  mmf_filter_checker filter_check (
    .clk           (clk),
    .rst           (rst),
    .request       (request_ch),
    .result        (result_ch),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request word, after a random gap while idle_on is set, and wait until it is taken.
  task automatic send_word(input cmd_t op, input logic [GROUP_W-1:0] group);
    int gap;
    begin
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        request_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      request_ch.valid <= 1'b1;
      request_ch.command <= op;
      request_ch.group_address <= group;
      do @(posedge clk); while (!(request_ch.valid && request_ch.ready));
      @(negedge clk);
    end
  endtask

  // Withdraw the request and hold the sender until every expected result
  // word has come back.
  task automatic drain;
    begin
      request_ch.valid <= 1'b0;
      wait (expected_left == 0);
      @(negedge clk);
    end
  endtask

  // A group from the pool with random upper bits, which the mapping drops.
  function automatic logic [GROUP_W-1:0] pool_group();
    logic [GROUP_W-LOW_W-1:0] upper;
    upper = (GROUP_W-LOW_W)'($urandom);
    return {upper, group_pool[$urandom_range(0, POOL_SIZE - 1)]};
  endfunction

  // Result side: random stalls, plus one long hold when asked for.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      @(negedge clk);
    end
  end

  // Cycle limit for a hung block.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int pick;
    int sent;
    request_ch.valid = 1'b0;
    request_ch.command = CMD_JOIN;
    request_ch.group_address = '0;
    idle_on = 1'b1;
    hold_results = 1'b0;

    // The pool holds both extremes of the low bits and avoids the sweep range.
    for (int i = 0; i < POOL_SIZE; i++) begin
      group_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : LOW_W'($urandom);
      if (group_pool[i][LOW_W-1:8] == FILL_BASE[LOW_W-1:8]) group_pool[i][LOW_W-1] ^= 1'b1;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words: empty snapshot, absent leave, reserved command,
    // address extremes, a shared MAC, removal of the last entry and
    // removal with the last entry moved into the gap.
    send_word(CMD_SNAP, 32'h0);
    send_word(CMD_LEAVE, 32'h1234_5678);
    send_word(CMD_RSVD, 32'hFFFF_FFFF);
    send_word(CMD_JOIN, 32'h0000_0000);
    send_word(CMD_JOIN, 32'hFFFF_FFFF);
    send_word(CMD_JOIN, 32'hE07F_FFFF);
    send_word(CMD_SNAP, 32'hFFFF_FFFF);
    send_word(CMD_LEAVE, 32'hFFFF_FFFF);
    send_word(CMD_LEAVE, 32'h007F_FFFF);
    send_word(CMD_LEAVE, 32'h8000_0000);
    send_word(CMD_JOIN, 32'hEF00_0001);
    send_word(CMD_JOIN, 32'hEF00_0002);
    send_word(CMD_JOIN, 32'hEF00_0003);
    send_word(CMD_LEAVE, 32'hEF00_0001);
    send_word(CMD_SNAP, 32'h0);
    send_word(CMD_LEAVE, 32'hEF00_0002);
    send_word(CMD_LEAVE, 32'hEF00_0003);
    send_word(CMD_SNAP, 32'h0);
    drain();

    // A lone entry with several references, which then stays for the rest
    // of the run.
    idle_on = 1'b0;
    repeat (3) send_word(CMD_JOIN, {9'h0EF, SAT_REF_LOW});
    send_word(CMD_LEAVE, {9'h1C0, SAT_REF_LOW});
    drain();

    // Random joins and leaves over a small pool so the table fills, spills
    // into the overflow counter and drains again.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_on = (seg % 3 != 1);
      if (seg == 2) hold_results = 1'b1;
      sent = 0;
      while (sent < SEGMENT_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) send_word(CMD_JOIN, pool_group());
        else if (pick < 80) send_word(CMD_LEAVE, pool_group());
        else if (pick < 90) send_word(CMD_SNAP, $urandom);
        else if (pick < 95) send_word(CMD_RSVD, $urandom);
        else send_word(($urandom_range(0, 1) == 0) ? CMD_JOIN : CMD_LEAVE, $urandom);
        if (pick < 90 || pick >= 95) sent++;
      end
      drain();
    end

    // Fill every slot, spill a few more groups into the overflow counter
    // and bring it back down by a few absent leaves.
    idle_on = 1'b0;
    for (int k = 0; k < MAX_ENTRIES_DEF; k++) begin
      send_word(CMD_JOIN, {9'h1FF, FILL_BASE + LOW_W'(k)});
    end
    repeat (4) send_word(CMD_JOIN, {9'h0A5, SPILL_LOW});
    repeat (3) send_word(CMD_LEAVE, {9'h15A, ABSENT_LOW});
    send_word(CMD_SNAP, 32'h0);
    request_ch.valid <= 1'b0;

    wait (expected_left == 0);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
